@@ sv/calculator_precedence_engine_macros.svh @@
// Assertion macros for the calculator precedence engine.
`ifndef CALCULATOR_PRECEDENCE_ENGINE_MACROS_SVH
`define CALCULATOR_PRECEDENCE_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define CPE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpe assertion failed");
// Next-cycle implication, disabled during reset.
`define CPE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpe assertion failed");
`else
`define CPE_ASSERT_IMP(label, clk, rst, ante, cons)
`define CPE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/cpe_pkg.sv @@
package cpe_pkg;

  // Q16.16 value format
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_BITS   = VALUE_BITS + FRAC_BITS;
  localparam int WIDE_BITS  = 2 * VALUE_BITS;
  localparam int CNT_BITS   = $clog2(DIV_BITS + 1);

  // Key codes
  localparam logic [2:0] CMD_NUM = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;
  localparam logic [2:0] CMD_EQU = 3'd5;
  localparam logic [2:0] CMD_CLR = 3'd6;
  localparam logic [2:0] CMD_BAD = 3'd7;
  localparam logic [2:0] OP_NONE = 3'd0;

  // Kind of the last accepted key
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;

  // Request and response between the engine and the serial mul/div unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } md_rsp_t;

  // Magnitude of a two's complement value (most negative maps to 2^(W-1))
  function automatic logic [VALUE_BITS-1:0] mag(input logic signed [VALUE_BITS-1:0] v);
    mag = v[VALUE_BITS-1] ? VALUE_BITS'(-v) : VALUE_BITS'(v);
  endfunction

endpackage

@@ sv/cpe_in_if.sv @@
interface cpe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic signed [31:0] operand;

  modport source (output valid, cmd, operand, input ready);
  modport sink   (input valid, cmd, operand, output ready);
endinterface

@@ sv/cpe_out_if.sv @@
interface cpe_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        div_error;
  logic        saturated;
  logic signed [31:0] current_result;

  modport source (output valid, accepted, div_error, saturated, current_result, input ready);
  modport sink   (input valid, accepted, div_error, saturated, current_result, output ready);
endinterface

@@ sv/cpe_muldiv.sv @@
module cpe_muldiv import cpe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  md_req_t                      req,
  input  logic signed [VALUE_BITS-1:0] a,
  input  logic signed [VALUE_BITS-1:0] b,
  output md_rsp_t                      rsp,
  output logic signed [VALUE_BITS-1:0] res
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIN  = 3'b100
  } md_state_t;

  md_state_t             state;
  logic [CNT_BITS-1:0]   cnt;
  logic                  is_div;
  logic                  neg;
  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] dv;
  logic [VALUE_BITS-1:0] acc_hi;
  logic [VALUE_BITS-1:0] acc_lo;
  logic [VALUE_BITS-1:0] rem;
  logic [DIV_BITS-1:0]   nq;

  logic [VALUE_BITS:0]   mul_sum;
  logic [VALUE_BITS:0]   div_try;
  logic                  div_ge;
  logic [WIDE_BITS-1:0]  val;
  logic                  sat;
  logic [VALUE_BITS-1:0] mres;

  // One multiplier bit or one quotient bit per cycle
  always_comb begin
    mul_sum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, x} : '0);
    div_try = {rem, nq[DIV_BITS-1]};
    div_ge  = div_try >= {1'b0, dv};
  end

  // Clamp the magnitude to the signed range
  always_comb begin
    val = is_div ? WIDE_BITS'(nq) : ({acc_hi, acc_lo} >> FRAC_BITS);
    if (neg) begin
      sat = (val[WIDE_BITS-1:VALUE_BITS] != '0) ||
            (val[VALUE_BITS-1] && (val[VALUE_BITS-2:0] != '0));
    end else begin
      sat = val[WIDE_BITS-1:VALUE_BITS-1] != '0;
    end
    if (sat) begin
      mres = neg ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      mres = val[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= MD_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (req.start) begin
            is_div <= req.is_div;
            neg    <= a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
            x      <= mag(a);
            dv     <= mag(b);
            acc_hi <= '0;
            acc_lo <= mag(b);
            rem    <= '0;
            nq     <= DIV_BITS'(mag(a)) << FRAC_BITS;
            cnt    <= req.is_div ? CNT_BITS'(DIV_BITS) : CNT_BITS'(VALUE_BITS);
            state  <= MD_RUN;
          end
        end
        MD_RUN: begin
          if (is_div) begin
            rem <= div_ge ? VALUE_BITS'(div_try - {1'b0, dv}) : div_try[VALUE_BITS-1:0];
            nq  <= {nq[DIV_BITS-2:0], div_ge};
          end else begin
            acc_hi <= mul_sum[VALUE_BITS:1];
            acc_lo <= {mul_sum[0], acc_lo[VALUE_BITS-1:1]};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CNT_BITS'(1)) begin
            state <= MD_FIN;
          end
        end
        MD_FIN: begin
          res      <= neg ? -$signed(mres) : $signed(mres);
          rsp.sat  <= sat;
          rsp.done <= 1'b1;
          state    <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule

@@ sv/calculator_precedence_engine.sv @@
// Channel | Role | Payload
// req     | sink | cmd, operand
// rsp     | src  | accepted, div_error, saturated, current_result
//
// One key at a time. Number, clear, ignored keys, a refused divide and a first
// operator go from ST_IDLE straight to ST_DONE; an add/subtract fold passes
// through ST_APPLY; a pending multiply or divide waits in ST_WAIT on the
// bit-serial mul/div unit (one bit per cycle over 32 or 48 bits), then goes
// through ST_APPLY. Reset is synchronous, active high. A result waiting on rsp
// holds the engine in its last step; req.ready is low while a key is in progress.
`include "calculator_precedence_engine_macros.svh"
module calculator_precedence_engine import cpe_pkg::*; (
  input logic     clk,
  input logic     rst,
  cpe_in_if.sink  req,
  cpe_out_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WAIT  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                      state;
  logic [1:0]                  last_kind;
  logic [2:0]                  last_op;
  logic [2:0]                  cmd_r;
  logic signed [VALUE_BITS-1:0] held;
  logic signed [VALUE_BITS-1:0] sum_value;
  logic                        sum_valid;
  logic signed [VALUE_BITS-1:0] term_value;
  logic                        term_valid;
  logic signed [VALUE_BITS-1:0] opv;
  logic                        acc_r;
  logic                        derr_r;
  logic                        sat_r;

  md_req_t                     md_req;
  md_rsp_t                     md_rsp;
  logic signed [VALUE_BITS-1:0] md_res;
  logic signed [VALUE_BITS-1:0] term_rd;
  logic signed [VALUE_BITS-1:0] held_neg;
  logic                        neg_sat;
  logic signed [VALUE_BITS:0]  add_full;
  logic                        add_sat;
  logic signed [VALUE_BITS-1:0] add_res;
  logic                        op_ok;
  logic                        cmd_term;
  logic                        cmd_expr;
  logic                        to_sum;
  logic                        out_load;

  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  assign req.ready = (state == ST_IDLE);
  assign term_rd   = term_valid ? term_value : '0;
  assign out_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // Key decode
  always_comb begin
    op_ok    = (req.cmd != CMD_NUM) && (req.cmd != CMD_CLR) && (req.cmd != CMD_BAD) &&
               (last_kind == KIND_NUM);
    cmd_term = (req.cmd == CMD_MUL) || (req.cmd == CMD_DIV);
    cmd_expr = (req.cmd == CMD_ADD) || (req.cmd == CMD_SUB);
    to_sum   = (cmd_r == CMD_ADD) || (cmd_r == CMD_SUB) || (cmd_r == CMD_EQU);
  end

  // Negation and saturating sum
  always_comb begin
    neg_sat  = (held == VMIN);
    held_neg = neg_sat ? VMAX : -held;
    add_full = {sum_value[VALUE_BITS-1], sum_value} + {opv[VALUE_BITS-1], opv};
    add_sat  = add_full[VALUE_BITS] != add_full[VALUE_BITS-1];
    if (add_sat) begin
      add_res = add_full[VALUE_BITS] ? VMIN : VMAX;
    end else begin
      add_res = add_full[VALUE_BITS-1:0];
    end
  end

  // Start the serial unit for a pending multiply or a nonzero divide
  always_comb begin
    md_req.start  = (state == ST_IDLE) && req.valid && op_ok &&
                    ((last_op == CMD_MUL) || ((last_op == CMD_DIV) && (held != '0)));
    md_req.is_div = (last_op == CMD_DIV);
  end

  cpe_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .a   (term_rd),
    .b   (held),
    .rsp (md_rsp),
    .res (md_res)
  );

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      last_kind  <= KIND_NONE;
      last_op    <= OP_NONE;
      held       <= '0;
      sum_value  <= '0;
      sum_valid  <= 1'b0;
      term_value <= '0;
      term_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      // Output valid: set on load, cleared on transfer
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_r  <= req.cmd;
            acc_r  <= 1'b0;
            derr_r <= 1'b0;
            sat_r  <= 1'b0;
            state  <= ST_DONE;
            if (req.cmd == CMD_NUM) begin
              if (last_kind != KIND_NUM) begin
                held      <= req.operand;
                last_kind <= KIND_NUM;
              end
            end else if (req.cmd == CMD_CLR) begin
              last_kind  <= KIND_NONE;
              last_op    <= OP_NONE;
              held       <= '0;
              sum_value  <= '0;
              sum_valid  <= 1'b0;
              term_value <= '0;
              term_valid <= 1'b0;
            end else if (op_ok) begin
              case (last_op) inside
                CMD_ADD, CMD_SUB: begin
                  opv   <= (last_op == CMD_SUB) ? held_neg : held;
                  sat_r <= (last_op == CMD_SUB) && neg_sat;
                  state <= ST_APPLY;
                end
                CMD_MUL: state <= ST_WAIT;
                CMD_DIV: begin
                  if (held == '0) begin
                    derr_r <= 1'b1;
                  end else begin
                    state <= ST_WAIT;
                  end
                end
                default: begin
                  if (cmd_term) begin
                    sum_value  <= '0;
                    sum_valid  <= 1'b0;
                    term_value <= held;
                    term_valid <= 1'b1;
                  end else if (cmd_expr) begin
                    sum_value  <= held;
                    sum_valid  <= 1'b1;
                    term_value <= '0;
                    term_valid <= 1'b0;
                  end
                  last_kind <= KIND_OP;
                  last_op   <= req.cmd;
                  acc_r     <= 1'b1;
                end
              endcase
            end
          end
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            opv   <= md_res;
            sat_r <= md_rsp.sat;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (to_sum) begin
            sum_value  <= sum_valid ? add_res : opv;
            sat_r      <= sat_r | (sum_valid & add_sat);
            sum_valid  <= 1'b1;
            term_value <= '0;
            term_valid <= 1'b0;
          end else begin
            term_value <= opv;
            term_valid <= 1'b1;
          end
          last_kind <= KIND_OP;
          last_op   <= cmd_r;
          acc_r     <= 1'b1;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            rsp.accepted       <= acc_r;
            rsp.div_error      <= derr_r;
            rsp.saturated      <= sat_r;
            rsp.current_result <= sum_valid ? sum_value : term_value;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `CPE_ASSERT_IMP(a_err_not_acc, clk, rst, rsp.valid && rsp.div_error, !rsp.accepted)
  `CPE_ASSERT_IMP(a_err_not_sat, clk, rst, rsp.valid && rsp.div_error, !rsp.saturated)
  `CPE_ASSERT_NXT(a_busy_after_in, clk, rst, req.valid && req.ready, state != ST_IDLE)

endmodule

@@ test/tb_calculator_precedence_engine.sv @@
`timescale 1ns / 100ps
module tb_calculator_precedence_engine;
  import cpe_pkg::*;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 600;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand;
  } key_t;

  typedef struct packed {
    logic               accepted;
    logic               div_error;
    logic               saturated;
    logic signed [31:0] current_result;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpe_in_if  req();
  cpe_out_if rsp();

  calculator_precedence_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [1:0] calc_kind;
  logic [2:0] calc_op;
  longint     calc_held, calc_sum, calc_term;
  bit         calc_sum_ok, calc_term_ok, calc_sat;

  key_t    key_queue[$];
  answer_t answer_queue[$];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_cycles = 0;
  bit      hold_go = 1'b0;
  int      mismatches = 0;
  int      quiet_cycles = 0;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) begin
      calc_sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      calc_sat = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // Products and quotients: 64-bit is wide enough for 32x32 and 48/32 bits
  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp_q(p / 65536);
  endfunction

  function automatic longint q_div(longint a, longint b);
    return clamp_q((a * 65536) / b);
  endfunction

  function automatic void sum_fold(longint v);
    calc_sum = calc_sum_ok ? clamp_q(calc_sum + v) : v;
    calc_sum_ok = 1'b1;
  endfunction

  function automatic void calc_clear();
    calc_kind = KIND_NONE;
    calc_op = OP_NONE;
    calc_held = 0;
    calc_sum = 0;
    calc_sum_ok = 1'b0;
    calc_term = 0;
    calc_term_ok = 1'b0;
  endfunction

  function automatic answer_t calc_press(key_t k);
    answer_t a;
    bit acc, derr, to_sum;
    longint t, v;
    acc = 1'b0;
    derr = 1'b0;
    calc_sat = 1'b0;
    if (k.cmd == CMD_NUM) begin
      if (calc_kind != KIND_NUM) begin
        calc_held = longint'(k.operand);
        calc_kind = KIND_NUM;
      end
    end else if (k.cmd == CMD_CLR) begin
      calc_clear();
    end else if (k.cmd != CMD_BAD && calc_kind == KIND_NUM) begin
      to_sum = (k.cmd == CMD_ADD || k.cmd == CMD_SUB || k.cmd == CMD_EQU);
      t = calc_term_ok ? calc_term : 0;
      v = 0;
      case (calc_op)
        CMD_ADD, CMD_SUB: v = (calc_op == CMD_SUB) ? clamp_q(-calc_held) : calc_held;
        CMD_MUL: v = q_mul(t, calc_held);
        CMD_DIV: begin
          if (calc_held == 0) derr = 1'b1;
          else v = q_div(t, calc_held);
        end
        default: ;
      endcase
      if (!derr) begin
        if (calc_op == OP_NONE || calc_op == CMD_EQU) begin
          if (k.cmd == CMD_MUL || k.cmd == CMD_DIV) begin
            calc_sum = 0;
            calc_sum_ok = 1'b0;
            calc_term = calc_held;
            calc_term_ok = 1'b1;
          end else if (k.cmd == CMD_ADD || k.cmd == CMD_SUB) begin
            calc_sum = calc_held;
            calc_sum_ok = 1'b1;
            calc_term = 0;
            calc_term_ok = 1'b0;
          end
        end else if (to_sum) begin
          sum_fold(v);
          calc_term = 0;
          calc_term_ok = 1'b0;
        end else begin
          calc_term = v;
          calc_term_ok = 1'b1;
        end
        calc_kind = KIND_OP;
        calc_op = k.cmd;
        acc = 1'b1;
      end else begin
        calc_sat = 1'b0;
      end
    end
    a.accepted = acc;
    a.div_error = derr;
    a.saturated = calc_sat;
    a.current_result = calc_sum_ok ? calc_sum[31:0] : calc_term[31:0];
    return a;
  endfunction

  // Driver: offers queued keys, random idle gaps
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.cmd <= CMD_NUM;
      req.operand <= '0;
    end else if (!req.valid || req.ready) begin
      if (key_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req.valid <= 1'b1;
        req.cmd <= key_queue[0].cmd;
        req.operand <= key_queue[0].operand;
        void'(key_queue.pop_front());
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, with one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_go && hold_cycles < HOLD_LEN) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      calc_clear();
    end else begin
      if (req.valid && req.ready) begin
        key_t k;
        k.cmd = req.cmd;
        k.operand = req.operand;
        answer_queue.insert(answer_queue.size(), calc_press(k));
      end
      if (rsp.valid && rsp.ready) begin
        got.accepted = rsp.accepted;
        got.div_error = rsp.div_error;
        got.saturated = rsp.saturated;
        got.current_result = rsp.current_result;
        if (answer_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = answer_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0b %0b %0b %h, got %0b %0b %0b %h",
                       want.accepted, want.div_error, want.saturated, want.current_result,
                       got.accepted, got.div_error, got.saturated, got.current_result);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return 32'sh00010000 * $signed($urandom_range(20)) - 32'sh000a0000;
      4: return $signed({{16{1'($urandom_range(1))}}, 16'($urandom)});
      default: return $signed(32'($urandom));
    endcase
  endfunction

  function automatic void add_key(logic [2:0] c, logic signed [31:0] v);
    key_t k;
    k.cmd = c;
    k.operand = v;
    key_queue.insert(key_queue.size(), k);
  endfunction

  task automatic add_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        // well-formed: number then operator
        add_key(CMD_NUM, rand_value());
        add_key(3'($urandom_range(CMD_ADD, CMD_EQU)), 32'($urandom));
      end else if (r < 84) begin
        add_key(CMD_CLR, 32'($urandom));
      end else begin
        add_key(3'($urandom_range(7)), rand_value());
      end
    end
  endtask

  task automatic drain();
    while (key_queue.size() > 0 || req.valid || answer_queue.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: precedence, extremes, div by zero, ignored keys, clear
    add_key(CMD_ADD, 0);
    add_key(CMD_NUM, 32'sh00020000);
    add_key(CMD_NUM, 32'sh00090000);
    add_key(CMD_ADD, 0);
    add_key(CMD_NUM, 32'sh00030000);
    add_key(CMD_MUL, 0);
    add_key(CMD_NUM, 32'sh00040000);
    add_key(CMD_EQU, 0);
    add_key(CMD_EQU, 0);
    add_key(CMD_NUM, 32'sh7fffffff);
    add_key(CMD_MUL, 0);
    add_key(CMD_NUM, 32'sh7fffffff);
    add_key(CMD_DIV, 0);
    add_key(CMD_NUM, 32'sh00000000);
    add_key(CMD_SUB, 0);
    add_key(CMD_NUM, 32'sh00000001);
    add_key(CMD_SUB, 0);
    add_key(CMD_NUM, 32'sh80000000);
    add_key(CMD_EQU, 0);
    add_key(CMD_BAD, 32'shffffffff);
    add_key(CMD_CLR, 0);
    add_key(CMD_NUM, 32'sh80000000);
    add_key(CMD_DIV, 0);
    add_key(CMD_NUM, 32'sh00000001);
    add_key(CMD_EQU, 0);
    drain();

    idle_pct = 0;  stall_pct = 0;  add_random(75); drain();
    idle_pct = 82; stall_pct = 0;  add_random(75); drain();
    idle_pct = 0;  stall_pct = 82; add_random(75); drain();
    idle_pct = 27; stall_pct = 27; add_random(40);
    hold_go = 1'b1;
    add_random(35); drain();

    repeat (80) @(posedge clk);
    if (mismatches == 0 && answer_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ calculator_precedence_engine.f @@
+incdir+sv
sv/cpe_pkg.sv
sv/cpe_in_if.sv
sv/cpe_out_if.sv
sv/cpe_muldiv.sv
sv/calculator_precedence_engine.sv
test/tb_calculator_precedence_engine.sv
